### hdl/mqbs_pkg.sv
// Package: shared types, constants and codes for the max queens search block.
package mqbs_pkg;

	localparam int MaxSizeDefault = 8;
	localparam logic [3:0] BoardSizeReset = 4'd8;

	localparam logic [1:0] ModePlace  = 2'd0;
	localparam logic [1:0] ModeSolve  = 2'd1;
	localparam logic [1:0] ModeClear  = 2'd2;
	localparam logic [1:0] ModeUnused = 2'd3;

	localparam logic [1:0] StOk       = 2'd0;
	localparam logic [1:0] StRange    = 2'd1;
	localparam logic [1:0] StFixed    = 2'd2;
	localparam logic [1:0] StAttacked = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] row;
		logic [2:0] column;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] out_column;
		logic [2:0] out_row;
		logic       occupied;
		logic [3:0] queen_count;
		logic       last;
	} out_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear_board;  // forget working board and fixed queens
		logic place_commit; // fix the latched queen
		logic best_reset;   // clear best board
		logic col_reset;    // column, count and try row to zero
		logic col_advance;  // step column (fixed column or empty choice)
		logic try_row;      // place latched try row in current column
		logic row_next;     // increment try row
		logic pop;          // return to previous free column
		logic save_best;    // copy working board to best if better
		logic emit_reset;   // emit column to zero
		logic emit_next;    // emit column increment
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic       at_end;      // column reached board size
		logic       col_fixed;   // current column holds a fixed queen
		logic       row_done;    // try row reached board size
		logic       col_done;    // rows and empty choice of this column all done
		logic       row_ok;      // try row not attacked
		logic       stack_empty; // no free column to return to
		logic       emit_last;   // emit column is size-1
		logic [1:0] place_st;    // status of the latched place request
	} dp_stat_t;

endpackage

### hdl/mqbs_datapath.sv
// Datapath: working board, best board, search column stack and attack check.
module mqbs_datapath import mqbs_pkg::*; #(
	parameter int MAX_SIZE = MaxSizeDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [3:0]                  board_size,
	input  logic                        load_in,
	input  in_word_t                    in_word,
	input  dp_cmd_t                     cmd,
	output dp_stat_t                    stat,
	output out_word_t                   emit_word
);
	localparam int CW = $clog2(MAX_SIZE + 2);
	localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

	logic [MAX_SIZE-1:0][IW-1:0] cell_row_q, best_row_q;
	logic [MAX_SIZE-1:0]         cell_used_q, best_used_q, fixed_q;
	// per column: row to resume from once this column is popped;
	// size+1 once the empty choice is done as well
	logic [MAX_SIZE-1:0][CW-1:0] resume_q;
	logic [CW-1:0]               col_q, count_q, best_count_q, emit_q, try_q;
	logic [2:0]                  req_row_q, req_col_q;
	logic [CW-1:0]               size_n;

	// effective size: zero acts as one, large values clip
	always_comb begin
		if (board_size == 4'd0) size_n = CW'(1);
		else if (32'(board_size) > MAX_SIZE) size_n = CW'(MAX_SIZE);
		else size_n = CW'(board_size);
	end

	// attack check of (c, r) against used columns below size
	function automatic logic hit(input logic [CW-1:0] c, input logic [CW:0] r,
		input logic [MAX_SIZE-1:0][IW-1:0] rows, input logic [MAX_SIZE-1:0] used,
		input logic [CW-1:0] n);
		logic h;
		logic [CW:0] dc, dr, ri;
		h = 1'b0;
		for (int i = 0; i < MAX_SIZE; i++) begin
			ri = (CW+1)'(rows[i]);
			dc = (CW+1)'(c) > (CW+1)'(i) ? (CW+1)'(c) - (CW+1)'(i)
				: (CW+1)'(i) - (CW+1)'(c);
			dr = ri > r ? ri - r : r - ri;
			if (i < 32'(n) && (CW+1)'(i) != (CW+1)'(c) && used[i] && (ri == r || dc == dr))
				h = 1'b1;
		end
		return h;
	endfunction

	// queens on columns below t (working board)
	function automatic logic [CW-1:0] pop_count(input logic [CW-1:0] t,
		input logic [MAX_SIZE-1:0] used);
		logic [CW-1:0] s;
		s = '0;
		for (int i = 0; i < MAX_SIZE; i++)
			if (CW'(i) < t && used[i]) s = s + CW'(1);
		return s;
	endfunction

	// free column stack: highest free column below col_q with choice made
	logic [MAX_SIZE-1:0] onstack;
	logic [CW-1:0]       top;
	logic                have_top;
	always_comb begin
		top = '0;
		have_top = 1'b0;
		for (int i = 0; i < MAX_SIZE; i++) begin
			onstack[i] = !fixed_q[i] && (CW'(i) < col_q);
			if (onstack[i]) begin
				top = CW'(i);
				have_top = 1'b1;
			end
		end
	end

	// status to controller
	always_comb begin
		stat.at_end      = col_q >= size_n;
		stat.col_fixed   = (col_q < CW'(MAX_SIZE)) ? fixed_q[col_q[IW-1:0]] : 1'b0;
		stat.row_done    = try_q >= size_n;
		stat.col_done    = try_q > size_n;
		stat.row_ok      = !hit(col_q, (CW+1)'(try_q), cell_row_q, cell_used_q, size_n);
		stat.stack_empty = !have_top;
		stat.emit_last   = emit_q + CW'(1) == size_n;
		if (32'(req_row_q) >= 32'(size_n) || 32'(req_col_q) >= 32'(size_n))
			stat.place_st = StRange;
		else if (fixed_q[IW'(req_col_q)])
			stat.place_st = StFixed;
		else if (hit(CW'(req_col_q), (CW+1)'(req_row_q), cell_row_q, cell_used_q, size_n))
			stat.place_st = StAttacked;
		else
			stat.place_st = StOk;
	end

	// result word for the current emit column
	always_comb begin
		emit_word = '0;
		emit_word.out_column  = 3'(emit_q);
		emit_word.occupied    = best_used_q[emit_q[IW-1:0]];
		emit_word.out_row     = best_used_q[emit_q[IW-1:0]] ? 3'(best_row_q[emit_q[IW-1:0]]) : 3'd0;
		emit_word.queen_count = 4'(best_count_q);
		emit_word.last        = stat.emit_last;
	end

	// request latch
	always_ff @(posedge clk) begin
		if (load_in) begin
			req_row_q <= in_word.row;
			req_col_q <= in_word.column;
		end
	end

	// board and search registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_row_q <= '0; cell_used_q <= '0; fixed_q <= '0;
			best_row_q <= '0; best_used_q <= '0; best_count_q <= '0;
			col_q <= '0; count_q <= '0; emit_q <= '0; try_q <= '0; resume_q <= '0;
		end else begin
			if (cmd.clear_board) begin
				cell_row_q <= '0; cell_used_q <= '0; fixed_q <= '0;
			end
			if (cmd.place_commit) begin
				cell_row_q[IW'(req_col_q)]  <= IW'(req_row_q);
				cell_used_q[IW'(req_col_q)] <= 1'b1;
				fixed_q[IW'(req_col_q)]     <= 1'b1;
			end
			if (cmd.best_reset) begin
				best_row_q <= '0; best_used_q <= '0; best_count_q <= '0;
			end
			if (cmd.col_reset) begin
				col_q <= '0; count_q <= '0; try_q <= '0;
			end
			if (cmd.col_advance) begin
				// fixed column counts its queen, free column is left empty
				if (stat.col_fixed) count_q <= count_q + CW'(1);
				else begin
					cell_used_q[col_q[IW-1:0]] <= 1'b0;
					cell_row_q[col_q[IW-1:0]]  <= '0;
					resume_q[col_q[IW-1:0]]    <= size_n + CW'(1); // both choices done
				end
				col_q <= col_q + CW'(1);
				try_q <= '0;
			end
			if (cmd.row_next) try_q <= try_q + CW'(1);
			if (cmd.try_row) begin
				cell_row_q[col_q[IW-1:0]]  <= IW'(try_q);
				cell_used_q[col_q[IW-1:0]] <= 1'b1;
				resume_q[col_q[IW-1:0]]    <= try_q + CW'(1);
				col_q   <= col_q + CW'(1);
				count_q <= count_q + CW'(1);
				try_q   <= '0;
			end
			if (cmd.pop) begin
				// back to top with the queens below it; resume its next choice
				col_q   <= top;
				try_q   <= resume_q[top[IW-1:0]];
				count_q <= pop_count(top, cell_used_q);
			end
			if (cmd.save_best && count_q > best_count_q) begin
				best_row_q   <= cell_row_q;
				best_used_q  <= cell_used_q;
				best_count_q <= count_q;
			end
			if (cmd.emit_reset) emit_q <= '0;
			if (cmd.emit_next)  emit_q <= emit_q + CW'(1);
		end
	end

endmodule

### hdl/mqbs_ctrl.sv
// Controller: sequences place, clear and the backtracking search and emission.
module mqbs_ctrl import mqbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      load_in,
	output dp_cmd_t   cmd,
	input  dp_stat_t  stat,
	input  out_word_t emit_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PLACE = 3'd1;
	localparam logic [2:0] S_SRCH  = 3'd2;
	localparam logic [2:0] S_EMPTY = 3'd3;
	localparam logic [2:0] S_BACK  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;
	localparam logic [2:0] S_WAIT  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       ov_q, ov_d;
	out_word_t  ow_q, ow_d;
	logic       take;

	assign take      = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE || (ov_q && out_stall);
	assign load_in   = take;
	assign out_valid = ov_q;
	assign out_word  = ow_q;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		ov_d    = ov_q && out_stall;
		ow_d    = ow_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					if (in_word.mode == ModePlace) state_d = S_PLACE;
					else if (in_word.mode == ModeClear) begin
						cmd.clear_board = 1'b1;
						ov_d = 1'b1;
						ow_d = '0;
						ow_d.last = 1'b1;
					end else if (in_word.mode == ModeSolve) begin
						cmd.best_reset = 1'b1;
						cmd.col_reset  = 1'b1;
						state_d = S_SRCH;
					end
				end
			end
			S_PLACE: begin
				cmd.place_commit = stat.place_st == StOk;
				ov_d = 1'b1;
				ow_d = '0;
				ow_d.status = stat.place_st;
				ow_d.last = 1'b1;
				state_d = S_IDLE;
			end
			S_SRCH: begin
				if (stat.at_end) begin
					cmd.save_best = 1'b1;
					state_d = S_BACK;
				end else if (stat.col_fixed) cmd.col_advance = 1'b1;
				else if (stat.col_done) state_d = S_BACK;
				else if (stat.row_done) state_d = S_EMPTY;
				else if (stat.row_ok) cmd.try_row = 1'b1;
				else cmd.row_next = 1'b1;
			end
			S_EMPTY: begin
				cmd.col_advance = 1'b1;
				state_d = S_SRCH;
			end
			S_BACK: begin
				if (stat.stack_empty) begin
					cmd.emit_reset = 1'b1;
					cmd.col_reset  = 1'b1;
					cmd.clear_board = 1'b0;
					state_d = S_WAIT;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_SRCH;
				end
			end
			S_WAIT: state_d = S_EMIT;
			S_EMIT: begin
				if (!ov_q || !out_stall) begin
					ov_d = 1'b1;
					ow_d = emit_word;
					cmd.emit_next = 1'b1;
					if (stat.emit_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) ow_q <= ow_d;

`ifndef SYNTHESIS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !take) else $error("word taken while busy");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_stall |=> ov_q && $stable(ow_q)) else $error("result lost");
	a_place_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PLACE |=> state_q == S_IDLE && ov_q) else $error("place result");
`endif

endmodule

### hdl/max_queens_backtrack_search_top.sv
// Top level: max queens search with fixed queens, valid/stall word channels.
// A clear word gives its result in the cycle after it is taken, a place word once
// its check in the place state is registered. A solve word runs a depth-first
// backtracking search: each row tried and each fixed column is a search step,
// a column is left empty through the empty state and the search backs up from
// a finished board or an exhausted column through the back state. Every complete
// board, empty columns included, is visited; fixed queens and smaller sizes cut the
// search sharply. Once the search ends, the wait state leads to emission and one
// result word per column follows, one per cycle while the receiver does not stall.
// The input stalls while a word is in work and while a result waits.
module max_queens_backtrack_search_top import mqbs_pkg::*; #(
	parameter int MAX_SIZE = MaxSizeDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);
	logic [3:0] board_size_q;
	logic       load_in;
	dp_cmd_t    cmd;
	dp_stat_t   stat;
	out_word_t  emit_word;

	// board size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) board_size_q <= BoardSizeReset;
		else if (cfg_we) board_size_q <= cfg_wdata;
	end

	mqbs_datapath #(.MAX_SIZE(MAX_SIZE)) u_dp (
		.clk, .arst_n, .board_size(board_size_q), .load_in, .in_word(in_data),
		.cmd, .stat, .emit_word
	);

	mqbs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_word(in_data), .load_in, .cmd,
		.stat, .emit_word, .out_valid, .out_stall, .out_word(out_data)
	);

endmodule
